// ===== hw/rtl/rlmi_pkg.sv =====
// Shared types, codes and helper functions of the radix literal parser.
package rlmi_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_beat_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [2:0] byte_index;
        logic [3:0] length_used;
        logic [1:0] status;
        logic       last_byte;
    } byte_beat_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_BIG     = 2'd2
    } status_t;

    typedef enum logic [7:0] {
        MODE_UNDEC = 8'b0000_0001,
        MODE_ZERO  = 8'b0000_0010,
        MODE_BIN   = 8'b0000_0100,
        MODE_HEX   = 8'b0000_1000,
        MODE_OCT   = 8'b0001_0000,
        MODE_DEC   = 8'b0010_0000,
        MODE_TRUE  = 8'b0100_0000,
        MODE_FALSE = 8'b1000_0000
    } mode_t;

    // Settings seen by both ends; eff_count is byte_count clamped to 1..MAX_BYTES
    typedef struct packed {
        logic [3:0] eff_count;
        logic       big_endian;
        logic       negate_result;
    } cfg_t;

    // Summary of one finished literal, queued next to its value
    typedef struct packed {
        logic [3:0] length_used;
        status_t    status;
    } lit_meta_t;

    localparam int META_W = $bits(lit_meta_t);

    localparam logic [1:0] REG_BYTE_COUNT    = 2'd0;
    localparam logic [1:0] REG_BIG_ENDIAN    = 2'd1;
    localparam logic [1:0] REG_NEGATE_RESULT = 2'd2;

    localparam logic [3:0] BYTE_COUNT_RESET = 4'd8;

    localparam logic [4:0] RADIX_BIN = 5'd2;
    localparam logic [4:0] RADIX_OCT = 5'd8;
    localparam logic [4:0] RADIX_DEC = 5'd10;
    localparam logic [4:0] RADIX_HEX = 5'd16;

    localparam logic [2:0] KW_TRUE_LEN  = 3'd4;
    localparam logic [2:0] KW_FALSE_LEN = 3'd5;

    // Returns {valid, value} of a hex-style digit character
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9")
        begin
            r = {1'b1, 4'(c - "0")};
        end
        else if (c >= "A" && c <= "F")
        begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        else if (c >= "a" && c <= "f")
        begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic [7:0] kw_true_char(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = "t";
            3'd1: r = "r";
            3'd2: r = "u";
            3'd3: r = "e";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_false_char(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = "f";
            3'd1: r = "a";
            3'd2: r = "l";
            3'd3: r = "s";
            3'd4: r = "e";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/rlmi_front.sv =====
// Front end: classifies characters, accumulates digits, finishes each literal.
module rlmi_front #(
    parameter int MAX_BYTES = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rlmi_pkg::cfg_t           cfg,
    input  logic                     char_valid,
    input  rlmi_pkg::char_beat_t     char_data,
    input  logic                     push_ready,
    output logic                     push_valid,
    output rlmi_pkg::lit_meta_t      push_meta,
    output logic [8*MAX_BYTES-1:0]   push_value
);

    localparam int VW = 8 * MAX_BYTES;
    localparam int PW = VW + 8;

    logic [VW-1:0]     value_reg, value_next;
    logic [3:0]        used_reg, used_next;
    rlmi_pkg::mode_t   mode_reg, mode_next;
    logic [2:0]        kp_reg, kp_next;
    rlmi_pkg::status_t err_reg, err_next;

    logic              accept;
    logic [7:0]        c;
    logic              dvalid;
    logic [3:0]        dval;
    logic              acc_en;
    logic [4:0]        radix;
    logic [PW-1:0]     wide;
    logic [PW-1:0]     prod;
    logic [7:0]        carry;
    rlmi_pkg::status_t fin_err;
    logic [VW-1:0]     fin_value;

    assign accept = char_valid && push_ready;
    assign c      = char_data.char_code;
    assign {dvalid, dval} = rlmi_pkg::digit_of(c);

    // Character classification
    always_comb
    begin
        mode_next = mode_reg;
        kp_next   = kp_reg;
        acc_en    = 1'b0;
        radix     = rlmi_pkg::RADIX_DEC;
        if (err_reg == rlmi_pkg::ST_OK)
        begin
            unique case (mode_reg)
                rlmi_pkg::MODE_UNDEC:
                begin
                    priority if (c == "0")
                    begin
                        mode_next = rlmi_pkg::MODE_ZERO;
                    end
                    else if (c == "t")
                    begin
                        mode_next = rlmi_pkg::MODE_TRUE;
                        kp_next   = 3'd1;
                    end
                    else if (c == "f")
                    begin
                        mode_next = rlmi_pkg::MODE_FALSE;
                        kp_next   = 3'd1;
                    end
                    else
                    begin
                        mode_next = rlmi_pkg::MODE_DEC;
                        acc_en    = 1'b1;
                        radix     = rlmi_pkg::RADIX_DEC;
                    end
                end
                rlmi_pkg::MODE_ZERO:
                begin
                    priority if (c == "b" || c == "B")
                    begin
                        mode_next = rlmi_pkg::MODE_BIN;
                    end
                    else if (c == "x" || c == "X")
                    begin
                        mode_next = rlmi_pkg::MODE_HEX;
                    end
                    else
                    begin
                        mode_next = rlmi_pkg::MODE_OCT;
                        acc_en    = 1'b1;
                        radix     = rlmi_pkg::RADIX_OCT;
                    end
                end
                rlmi_pkg::MODE_BIN:
                begin
                    acc_en = 1'b1;
                    radix  = rlmi_pkg::RADIX_BIN;
                end
                rlmi_pkg::MODE_HEX:
                begin
                    acc_en = 1'b1;
                    radix  = rlmi_pkg::RADIX_HEX;
                end
                rlmi_pkg::MODE_OCT:
                begin
                    acc_en = 1'b1;
                    radix  = rlmi_pkg::RADIX_OCT;
                end
                rlmi_pkg::MODE_DEC:
                begin
                    acc_en = 1'b1;
                    radix  = rlmi_pkg::RADIX_DEC;
                end
                rlmi_pkg::MODE_TRUE:
                begin
                    if (kp_reg < rlmi_pkg::KW_TRUE_LEN && c == rlmi_pkg::kw_true_char(kp_reg))
                    begin
                        kp_next = kp_reg + 3'd1;
                    end
                end
                rlmi_pkg::MODE_FALSE:
                begin
                    if (kp_reg < rlmi_pkg::KW_FALSE_LEN
                        && c == rlmi_pkg::kw_false_char(kp_reg))
                    begin
                        kp_next = kp_reg + 3'd1;
                    end
                end
                default:
                begin
                    mode_next = rlmi_pkg::MODE_UNDEC;
                end
            endcase
        end
    end

    // Multiply by the radix with shifts and add the digit
    always_comb
    begin
        wide = {8'd0, value_reg};
        unique case (radix)
            rlmi_pkg::RADIX_BIN: prod = (wide << 1) + PW'(dval);
            rlmi_pkg::RADIX_OCT: prod = (wide << 3) + PW'(dval);
            rlmi_pkg::RADIX_HEX: prod = (wide << 4) + PW'(dval);
            default:             prod = (wide << 3) + (wide << 1) + PW'(dval);
        endcase
        // The only byte above the significant ones that can turn nonzero
        carry = 8'd0;
        for (int i = 1; i <= MAX_BYTES; i++)
        begin
            if (used_reg == 4'(i))
            begin
                carry = prod[8*i +: 8];
            end
        end
    end

    // Accumulate, flag errors, then finish the literal on its last beat
    always_comb
    begin
        value_next = value_reg;
        used_next  = used_reg;
        err_next   = err_reg;
        if (err_reg == rlmi_pkg::ST_OK)
        begin
            if (acc_en)
            begin
                if (!dvalid || {1'b0, dval} >= radix)
                begin
                    err_next = rlmi_pkg::ST_INVALID;
                end
                else if (carry != 8'd0 && used_reg >= cfg.eff_count)
                begin
                    err_next = rlmi_pkg::ST_BIG;
                    // keep the low bytes of the truncated product
                    for (int i = 0; i < MAX_BYTES; i++)
                    begin
                        if (4'(i) < used_reg)
                        begin
                            value_next[8*i +: 8] = prod[8*i +: 8];
                        end
                    end
                end
                else
                begin
                    value_next = prod[VW-1:0];
                    if (carry != 8'd0)
                    begin
                        used_next = used_reg + 4'd1;
                    end
                end
            end
            else if ((mode_reg == rlmi_pkg::MODE_TRUE || mode_reg == rlmi_pkg::MODE_FALSE)
                     && kp_next == kp_reg)
            begin
                err_next = rlmi_pkg::ST_INVALID;
            end
        end

        fin_err   = err_next;
        fin_value = value_next;
        if (fin_err == rlmi_pkg::ST_OK)
        begin
            if (mode_next == rlmi_pkg::MODE_TRUE)
            begin
                if (kp_next == rlmi_pkg::KW_TRUE_LEN)
                begin
                    fin_value[7:0] = 8'd1;
                end
                else
                begin
                    fin_err = rlmi_pkg::ST_INVALID;
                end
            end
            else if (mode_next == rlmi_pkg::MODE_FALSE && kp_next != rlmi_pkg::KW_FALSE_LEN)
            begin
                fin_err = rlmi_pkg::ST_INVALID;
            end
        end
        if (fin_err == rlmi_pkg::ST_OK && used_next > cfg.eff_count)
        begin
            fin_err = rlmi_pkg::ST_BIG;
        end
    end

    assign push_valid            = accept && char_data.last_char;
    assign push_value            = fin_value;
    assign push_meta.status      = fin_err;
    assign push_meta.length_used = (fin_err == rlmi_pkg::ST_OK) ? used_next : cfg.eff_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            used_reg  <= 4'd1;
            mode_reg  <= rlmi_pkg::MODE_UNDEC;
            kp_reg    <= 3'd0;
            err_reg   <= rlmi_pkg::ST_OK;
        end
        else if (accept)
        begin
            if (char_data.last_char)
            begin
                // clear for the next literal
                value_reg <= '0;
                used_reg  <= 4'd1;
                mode_reg  <= rlmi_pkg::MODE_UNDEC;
                kp_reg    <= 3'd0;
                err_reg   <= rlmi_pkg::ST_OK;
            end
            else
            begin
                value_reg <= value_next;
                used_reg  <= used_next;
                mode_reg  <= mode_next;
                kp_reg    <= kp_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

// ===== hw/rtl/rlmi_queue.sv =====
// Short queue of finished literals between the front and back ends.
module rlmi_queue #(
    parameter int WIDTH = 70,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/rlmi_back.sv =====
// Back end: optionally negates and orders a literal, one byte beat per cycle unless stalled.
module rlmi_back #(
    parameter int MAX_BYTES = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rlmi_pkg::cfg_t           cfg,
    input  logic                     pop_valid,
    output logic                     pop_ready,
    input  rlmi_pkg::lit_meta_t      pop_meta,
    input  logic [8*MAX_BYTES-1:0]   pop_value,
    output logic                     byte_valid,
    input  logic                     byte_ready,
    output rlmi_pkg::byte_beat_t     byte_data
);

    localparam int VW = 8 * MAX_BYTES;

    logic                 busy_reg, busy_next;
    logic [2:0]           k_reg, k_next;
    logic [VW-1:0]        val_reg, val_next;
    rlmi_pkg::lit_meta_t  meta_reg, meta_next;
    logic                 out_valid_reg, out_valid_next;
    rlmi_pkg::byte_beat_t out_data_reg, out_data_next;

    logic                 step;
    logic                 is_last;
    logic                 load;
    logic [2:0]           src;
    logic [7:0]           sel_byte;

    assign step      = busy_reg && (!out_valid_reg || byte_ready);
    assign is_last   = {1'b0, k_reg} == cfg.eff_count - 4'd1;
    assign pop_ready = !busy_reg || (step && is_last);
    assign load      = pop_valid && pop_ready;
    assign src       = cfg.big_endian ? 3'(cfg.eff_count - 4'd1 - {1'b0, k_reg}) : k_reg;

    always_comb
    begin
        sel_byte = 8'd0;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (src == 3'(i))
            begin
                sel_byte = val_reg[8*i +: 8];
            end
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        k_next         = k_reg;
        val_next       = val_reg;
        meta_next      = meta_reg;
        out_valid_next = out_valid_reg && !byte_ready;
        out_data_next  = out_data_reg;
        if (step)
        begin
            out_valid_next            = 1'b1;
            out_data_next.byte_value  = sel_byte;
            out_data_next.byte_index  = k_reg;
            out_data_next.length_used = meta_reg.length_used;
            out_data_next.status      = meta_reg.status;
            out_data_next.last_byte   = is_last;
            k_next                    = k_reg + 3'd1;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            // two's complement of the whole store; only the low bytes go out
            busy_next = 1'b1;
            k_next    = 3'd0;
            meta_next = pop_meta;
            val_next  = cfg.negate_result ? (~pop_value) + VW'(1) : pop_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        meta_reg     <= meta_next;
        out_data_reg <= out_data_next;
    end

    assign byte_valid = out_valid_reg;
    assign byte_data  = out_data_reg;

endmodule

// ===== hw/rtl/radix_literal_to_multibyte_int_top.sv =====
// Top level of the radix literal parser: configuration registers and the two ends.
//
//   channel   direction  handshake                      payload
//   char      in         char_valid / char_ready        char_data   (rlmi_pkg::char_beat_t)
//   byte      out        byte_valid / byte_ready        byte_data   (rlmi_pkg::byte_beat_t)
//   config    in         psel / penable / pwrite        paddr, pwdata, prdata (APB)
//
// One character beat is taken per cycle while char_ready is high; the front end's
// shift-and-add accumulator finishes each character in that cycle.
// A literal's last character yields eff_count byte beats (byte_count clamped to 1..MAX_BYTES),
// one per cycle while byte_ready is high, from the back end's output register.
// A two-entry queue of finished literals lets the front keep parsing while bytes drain;
// char_ready drops only while that queue is full.
// Reset sets byte_count to 8, big_endian and negate_result to 0, and empties the parser.
module radix_literal_to_multibyte_int_top #(
    parameter int MAX_BYTES = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  rlmi_pkg::char_beat_t char_data,
    output logic                 byte_valid,
    input  logic                 byte_ready,
    output rlmi_pkg::byte_beat_t byte_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int VW = 8 * MAX_BYTES;
    localparam int QW = rlmi_pkg::META_W + VW;

    logic [3:0]          byte_count_reg;
    logic                big_endian_reg;
    logic                negate_result_reg;
    rlmi_pkg::cfg_t      cfg;
    logic                cfg_write;

    logic                push_valid;
    logic                push_ready;
    rlmi_pkg::lit_meta_t push_meta;
    logic [VW-1:0]       push_value;
    logic                pop_valid;
    logic                pop_ready;
    logic [QW-1:0]       pop_data;
    rlmi_pkg::lit_meta_t pop_meta;
    logic [VW-1:0]       pop_value;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= rlmi_pkg::BYTE_COUNT_RESET;
            big_endian_reg    <= 1'b0;
            negate_result_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                rlmi_pkg::REG_BYTE_COUNT:    byte_count_reg    <= pwdata[3:0];
                rlmi_pkg::REG_BIG_ENDIAN:    big_endian_reg    <= pwdata[0];
                rlmi_pkg::REG_NEGATE_RESULT: negate_result_reg <= pwdata[0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rlmi_pkg::REG_BYTE_COUNT:    prdata = {28'd0, byte_count_reg};
            rlmi_pkg::REG_BIG_ENDIAN:    prdata = {31'd0, big_endian_reg};
            rlmi_pkg::REG_NEGATE_RESULT: prdata = {31'd0, negate_result_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // Clamp byte_count to 1..MAX_BYTES
    always_comb
    begin
        priority if (byte_count_reg == 4'd0)
        begin
            cfg.eff_count = 4'd1;
        end
        else if (byte_count_reg > 4'(MAX_BYTES))
        begin
            cfg.eff_count = 4'(MAX_BYTES);
        end
        else
        begin
            cfg.eff_count = byte_count_reg;
        end
        cfg.big_endian    = big_endian_reg;
        cfg.negate_result = negate_result_reg;
    end

    assign char_ready = push_ready;

    rlmi_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .char_valid (char_valid),
        .char_data  (char_data),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_meta  (push_meta),
        .push_value (push_value)
    );

    rlmi_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_meta, push_value}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_meta  = pop_data[QW-1 -: rlmi_pkg::META_W];
    assign pop_value = pop_data[VW-1:0];

    rlmi_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_meta   (pop_meta),
        .pop_value  (pop_value),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data)
    );

endmodule

// ===== hw/rtl/rlmi_checker.sv =====
// Port-level checks on the byte stream of the radix literal parser, bound to the top.
module rlmi_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 byte_valid,
    input logic                 byte_ready,
    input rlmi_pkg::byte_beat_t byte_data
);

    // Hold a stalled beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid && $stable(byte_data))
        else $error("byte beat changed while stalled");

    // A run continues without a gap and with the next index
    a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && !byte_data.last_byte
        |=> byte_valid && byte_data.byte_index == $past(byte_data.byte_index) + 3'd1)
        else $error("byte run broke or skipped an index");

    // Length and status stay fixed within a run
    a_run_meta: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && !byte_data.last_byte
        |=> $stable(byte_data.length_used) && $stable(byte_data.status))
        else $error("length or status changed within a run");

    // Length is never zero and status is a defined code
    a_meta_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid |-> byte_data.length_used != 4'd0 && byte_data.status != 2'd3)
        else $error("length or status out of range");

endmodule

bind radix_literal_to_multibyte_int_top rlmi_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data)
);

// ===== tb/radix_literal_to_multibyte_int_top_test.sv =====
// Self-checking testbench of the radix literal parser: character beats in, checked byte beats out.
`timescale 1ns / 100ps

module radix_literal_to_multibyte_int_top_test;

    localparam int MAX_BYTES = 8;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic [7:0] text_t[$];

    // Tracks the literal being parsed and the byte beats it must produce
    class int_literal_tracker;
        rlmi_pkg::byte_beat_t bytes_due[$];
        logic [7:0]           acc[MAX_BYTES];
        int unsigned          n_sig;
        rlmi_pkg::mode_t      radix_mode;
        int unsigned          kw_pos;
        rlmi_pkg::status_t    err;
        logic [3:0]           byte_count;
        logic                 big_endian;
        logic                 negate_result;
        int                   errors;

        function new();
            byte_count = rlmi_pkg::BYTE_COUNT_RESET;
            big_endian = 1'b0;
            negate_result = 1'b0;
            errors = 0;
            clear();
        endfunction

        function void clear();
            foreach (acc[i])
            begin
                acc[i] = 8'h00;
            end
            n_sig = 1;
            radix_mode = rlmi_pkg::MODE_UNDEC;
            kw_pos = 0;
            err = rlmi_pkg::ST_OK;
        endfunction

        function int unsigned eff();
            if (byte_count == 0)
            begin
                return 1;
            end
            if (byte_count > MAX_BYTES)
            begin
                return MAX_BYTES;
            end
            return byte_count;
        endfunction

        function void add_digit(logic [7:0] c, int unsigned radix);
            int          d;
            int unsigned carry;
            int unsigned n;
            d = -1;
            if (c >= "0" && c <= "9")
            begin
                d = c - "0";
            end
            else if (c >= "A" && c <= "F")
            begin
                d = c - "A" + 10;
            end
            else if (c >= "a" && c <= "f")
            begin
                d = c - "a" + 10;
            end
            if (d < 0 || d >= radix)
            begin
                err = rlmi_pkg::ST_INVALID;
                return;
            end
            n = (n_sig > MAX_BYTES) ? MAX_BYTES : n_sig;
            carry = d;
            for (int i = 0; i < n; i++)
            begin
                carry = acc[i] * radix + carry;
                acc[i] = carry[7:0];
                carry = carry >> 8;
            end
            if (carry != 0)
            begin
                // overflow keeps the truncated product in the store
                if (n >= eff())
                begin
                    err = rlmi_pkg::ST_BIG;
                    return;
                end
                acc[n] = carry[7:0];
                n_sig = n + 1;
            end
        endfunction

        function void match_kw(logic [7:0] c, string kw);
            if (kw_pos < kw.len() && c == kw[kw_pos])
            begin
                kw_pos++;
            end
            else
            begin
                err = rlmi_pkg::ST_INVALID;
            end
        endfunction

        function void take_char(rlmi_pkg::char_beat_t b);
            int unsigned n;
            int unsigned len;
            int unsigned carry;
            int unsigned src;
            logic [7:0]  c;
            c = b.char_code;
            if (err == rlmi_pkg::ST_OK)
            begin
                case (radix_mode)
                    rlmi_pkg::MODE_UNDEC:
                    begin
                        if (c == "0")
                        begin
                            radix_mode = rlmi_pkg::MODE_ZERO;
                        end
                        else if (c == "t")
                        begin
                            radix_mode = rlmi_pkg::MODE_TRUE;
                            kw_pos = 1;
                        end
                        else if (c == "f")
                        begin
                            radix_mode = rlmi_pkg::MODE_FALSE;
                            kw_pos = 1;
                        end
                        else
                        begin
                            radix_mode = rlmi_pkg::MODE_DEC;
                            add_digit(c, rlmi_pkg::RADIX_DEC);
                        end
                    end
                    rlmi_pkg::MODE_ZERO:
                    begin
                        if (c == "b" || c == "B")
                        begin
                            radix_mode = rlmi_pkg::MODE_BIN;
                        end
                        else if (c == "x" || c == "X")
                        begin
                            radix_mode = rlmi_pkg::MODE_HEX;
                        end
                        else
                        begin
                            radix_mode = rlmi_pkg::MODE_OCT;
                            add_digit(c, rlmi_pkg::RADIX_OCT);
                        end
                    end
                    rlmi_pkg::MODE_BIN:  add_digit(c, rlmi_pkg::RADIX_BIN);
                    rlmi_pkg::MODE_HEX:  add_digit(c, rlmi_pkg::RADIX_HEX);
                    rlmi_pkg::MODE_OCT:  add_digit(c, rlmi_pkg::RADIX_OCT);
                    rlmi_pkg::MODE_DEC:  add_digit(c, rlmi_pkg::RADIX_DEC);
                    rlmi_pkg::MODE_TRUE: match_kw(c, "true");
                    default:             match_kw(c, "false");
                endcase
            end
            if (!b.last_char)
            begin
                return;
            end

            // a keyword must be complete to count
            if (err == rlmi_pkg::ST_OK)
            begin
                if (radix_mode == rlmi_pkg::MODE_TRUE)
                begin
                    if (kw_pos == rlmi_pkg::KW_TRUE_LEN)
                    begin
                        acc[0] = 8'h01;
                    end
                    else
                    begin
                        err = rlmi_pkg::ST_INVALID;
                    end
                end
                else if (radix_mode == rlmi_pkg::MODE_FALSE
                         && kw_pos != rlmi_pkg::KW_FALSE_LEN)
                begin
                    err = rlmi_pkg::ST_INVALID;
                end
            end

            n = eff();
            if (err == rlmi_pkg::ST_OK && n_sig > n)
            begin
                err = rlmi_pkg::ST_BIG;
            end
            len = (err == rlmi_pkg::ST_OK) ? n_sig : n;

            if (negate_result)
            begin
                carry = 1;
                for (int i = 0; i < n; i++)
                begin
                    carry = (acc[i] ^ 8'hFF) + carry;
                    acc[i] = carry[7:0];
                    carry = carry >> 8;
                end
            end

            for (int k = 0; k < n; k++)
            begin
                src = big_endian ? (n - 1 - k) : k;
                bytes_due.push_back('{byte_value:  acc[src],
                                      byte_index:  k[2:0],
                                      length_used: len[3:0],
                                      status:      err,
                                      last_byte:   (k == n - 1)});
            end
            clear();
        endfunction

        function void flag(string field, int unsigned want, int unsigned got);
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_byte(rlmi_pkg::byte_beat_t got);
            rlmi_pkg::byte_beat_t want;
            if (bytes_due.size() == 0)
            begin
                $display("%0t: unexpected byte beat %0h", $time, got);
                errors++;
                return;
            end
            want = bytes_due.pop_front();
            if (got.byte_value !== want.byte_value)
            begin
                flag("byte_value", want.byte_value, got.byte_value);
            end
            if (got.byte_index !== want.byte_index)
            begin
                flag("byte_index", want.byte_index, got.byte_index);
            end
            if (got.length_used !== want.length_used)
            begin
                flag("length_used", want.length_used, got.length_used);
            end
            if (got.status !== want.status)
            begin
                flag("status", want.status, got.status);
            end
            if (got.last_byte !== want.last_byte)
            begin
                flag("last_byte", want.last_byte, got.last_byte);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 char_valid = 1'b0;
    logic                 char_ready;
    rlmi_pkg::char_beat_t char_data = '0;
    logic                 byte_valid;
    logic                 byte_ready = 1'b0;
    rlmi_pkg::byte_beat_t byte_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [3:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int_literal_tracker sb = new();

    int cycles = 0;
    bit calm = 1'b0;
    int burst_left = 0;
    int ready_run = 0;
    int ready_hold = 0;

    radix_literal_to_multibyte_int_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[radix_literal_to_multibyte_int_top] ERROR");
        $finish;
    end

    // Receiver: runs of ready broken by stalls, no stalls while calm
    always @(posedge clk)
    begin
        if (ready_run > 0)
        begin
            ready_run--;
            byte_ready <= 1'b1;
        end
        else if (ready_hold > 0)
        begin
            ready_hold--;
            byte_ready <= 1'b0;
        end
        else
        begin
            ready_run = $urandom_range(1, 20);
            ready_hold = calm ? 0 : $urandom_range(1, 6);
            byte_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && char_ready)
            begin
                sb.take_char(char_data);
            end
            if (byte_valid && byte_ready)
            begin
                sb.check_byte(byte_data);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            rlmi_pkg::REG_BYTE_COUNT:    sb.byte_count = val[3:0];
            rlmi_pkg::REG_BIG_ENDIAN:    sb.big_endian = val[0];
            rlmi_pkg::REG_NEGATE_RESULT: sb.negate_result = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Hold the beat until accepted; unless calm, open a random gap, maybe none, before each new burst
    task automatic push_char(input logic [7:0] c, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = calm ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        char_valid <= 1'b1;
        char_data <= '{char_code: c, last_char: lst};
        @(posedge clk);
        while (!char_ready) @(posedge clk);
    endtask

    task automatic send_text(input text_t t);
        foreach (t[i])
        begin
            push_char(t[i], i == t.size() - 1);
        end
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (sb.bytes_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    function automatic text_t to_text(string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
        begin
            t.push_back(s[i]);
        end
        return t;
    endfunction

    // Mostly well-formed literals sized to the current byte count, some broken or noise
    function automatic text_t make_literal();
        text_t       t;
        string       digs;
        int unsigned bc;
        int unsigned ndig;
        bc = sb.eff();
        digs = "0";
        ndig = 0;
        case ($urandom_range(0, 5))
            0:
            begin
                digs = "0123456789";
                t.push_back(digs[$urandom_range(1, 9)]);
                ndig = $urandom_range(0, bc * 5 / 2 + 1);
            end
            1:
            begin
                t.push_back("0");
                t.push_back($urandom_range(0, 1) ? "x" : "X");
                digs = "0123456789abcdefABCDEF";
                ndig = $urandom_range(0, 2 * bc + 1);
            end
            2:
            begin
                t.push_back("0");
                t.push_back($urandom_range(0, 1) ? "b" : "B");
                digs = "01";
                ndig = $urandom_range(0, 8 * bc + 1);
            end
            3:
            begin
                t.push_back("0");
                digs = "01234567";
                ndig = $urandom_range(1, 8 * bc / 3 + 2);
            end
            4: t = to_text($urandom_range(0, 1) ? "true" : "false");
            default: t.push_back("0");
        endcase
        repeat (ndig) t.push_back(digs[$urandom_range(0, digs.len() - 1)]);
        case ($urandom_range(0, 19))
            0, 1, 2: t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
            3:
            begin
                if (t.size() > 1)
                begin
                    void'(t.pop_back());
                end
            end
            4, 5, 6:
            begin
                t.delete();
                repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        return t;
    endfunction

    initial
    begin
        int    bc_plan[7]  = '{8, 0, 15, -1, -1, 1, 8};
        int    be_plan[7]  = '{1, 0, 0, -1, -1, 1, 0};
        int    neg_plan[7] = '{1, 1, 0, -1, -1, 0, 0};
        int    bc;
        int    sent;
        text_t lit;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: keywords, prefixes, bad digits, extreme codes, overflow of one byte
        write_reg(rlmi_pkg::REG_BYTE_COUNT, 32'd1);
        write_reg(rlmi_pkg::REG_BIG_ENDIAN, 32'd0);
        write_reg(rlmi_pkg::REG_NEGATE_RESULT, 32'd0);
        send_text(to_text("0"));
        send_text(to_text("true"));
        send_text(to_text("false"));
        send_text(to_text("fx"));
        send_text(to_text("0x"));
        send_text(to_text("0b1"));
        send_text(to_text("08"));
        send_text(to_text("F"));
        send_text('{8'hFF});
        send_text('{8'h00});
        send_text(to_text("256"));
        char_valid <= 1'b0;

        for (int p = 0; p < 7; p++)
        begin
            wait_drained();
            calm = (p == 0 || p == 6);
            bc = (bc_plan[p] < 0) ? $urandom_range(2, 7) : bc_plan[p];
            write_reg(rlmi_pkg::REG_BYTE_COUNT, bc);
            write_reg(rlmi_pkg::REG_BIG_ENDIAN,
                      (be_plan[p] < 0) ? $urandom_range(0, 1) : be_plan[p]);
            write_reg(rlmi_pkg::REG_NEGATE_RESULT,
                      (neg_plan[p] < 0) ? $urandom_range(0, 1) : neg_plan[p]);
            sent = 0;
            while (sent < 32)
            begin
                lit = make_literal();
                send_text(lit);
                sent += lit.size();
            end
            char_valid <= 1'b0;
        end

        wait_drained();
        repeat (12) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("[radix_literal_to_multibyte_int_top] OK");
        end
        else
        begin
            $display("[radix_literal_to_multibyte_int_top] ERROR");
        end
        $finish;
    end

endmodule
